/* rtl/period_average_pitch_classifier_assert.svh */
// assertion macros for the period average pitch classifier
// used by period_average_pitch_classifier.sv; no other dependencies
`ifndef PERIOD_AVERAGE_PITCH_CLASSIFIER_ASSERT_SVH
`define PERIOD_AVERAGE_PITCH_CLASSIFIER_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define PAPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("papc assertion failed: same-cycle check");

// next-cycle implication, skipped while reset is high
`define PAPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("papc assertion failed: next-cycle check");

`endif

/* rtl/papc_pkg.sv */
// shared constants for the period average pitch classifier
// no dependencies; used by period_average_pitch_classifier.sv
`default_nettype none

package papc_pkg;

   localparam int WINDOW     = 5;
   localparam int DATA_W     = 16;
   localparam int LED_W      = 15;
   localparam int NUM_THRESH = LED_W - 1;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = DATA_W + $clog2(WINDOW);

   // divide by window as multiply by rounded-up reciprocal, exact for SUM_W-bit sums
   localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + MULT_W;
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   localparam logic [DATA_W-1:0] THRESH [NUM_THRESH] = '{
      16'd8922, 16'd8948, 16'd8974, 16'd8999, 16'd9025, 16'd9052, 16'd9078,
      16'd9104, 16'd9130, 16'd9157, 16'd9184, 16'd9210, 16'd9236, 16'd9263
   };

   localparam logic OP_CAPTURE  = 1'b0;
   localparam logic OP_OVERFLOW = 1'b1;

endpackage

`default_nettype wire

/* rtl/period_average_pitch_classifier.sv */
// period average pitch classifier: capture ring, running sum, divide, led binning
// depends on papc_pkg and period_average_pitch_classifier_assert.svh
//
// usage
//   req channel: req_valid/req_stall carry one item, an operation bit and a
//   16-bit captured period. a capture replaces the oldest of the last window
//   entries; an overflow item clears ring, sum and warm-up count.
//   rsp channel: rsp_valid/rsp_stall carry rsp_leds (one-hot pitch bin,
//   bit 14 far sharp, bit 0 far flat) and rsp_average (sum / window).
//   the first window captures after reset or overflow give no item; each
//   later capture gives one item. an overflow gives leds and average of zero.
//   path: an accepted item passes the input register, the state update, the
//   reciprocal multiply and the bin compare before it shows on rsp.
//   throughput: one item per cycle while rsp_stall is low; the running sum
//   register updates once per item, which sets that figure.
//   stall: each stage holds while the next is full and stalled; req_stall
//   rises only once all stages are full and rsp_stall is high.
//   reset: synchronous, active high; clears ring, sum, slot, count and all
//   valid bits.
`default_nettype none

module period_average_pitch_classifier (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_operation,
   input  wire logic [papc_pkg::DATA_W-1:0] req_capture_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [papc_pkg::LED_W-1:0]       rsp_leds,
   output logic [papc_pkg::DATA_W-1:0]      rsp_average
);

   `include "period_average_pitch_classifier_assert.svh"

   logic out_free, s3_free, s2_free, s1_free, s1_fire;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_op_ff, s1_op_in;
   logic [papc_pkg::DATA_W-1:0]   s1_cap_ff, s1_cap_in;

   logic [papc_pkg::DATA_W-1:0]   ring_ff [papc_pkg::WINDOW];
   logic [papc_pkg::DATA_W-1:0]   ring_in [papc_pkg::WINDOW];
   logic [papc_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [papc_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [papc_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_upd;

   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_ovf_ff, s2_ovf_in;
   logic [papc_pkg::SUM_W-1:0]    s2_sum_ff, s2_sum_in;
   logic [papc_pkg::PROD_W-1:0]   product;

   logic                          s3_valid_ff, s3_valid_in;
   logic                          s3_ovf_ff, s3_ovf_in;
   logic [papc_pkg::DATA_W-1:0]   s3_avg_ff, s3_avg_in;
   logic [papc_pkg::NUM_THRESH-1:0] at_or_above;
   logic [papc_pkg::LED_W-1:0]    bin_leds;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [papc_pkg::LED_W-1:0]    rsp_leds_ff, rsp_leds_in;
   logic [papc_pkg::DATA_W-1:0]   rsp_avg_ff, rsp_avg_in;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s3_free   = !s3_valid_ff || out_free;
      s2_free   = !s2_valid_ff || s3_free;
      s1_free   = !s1_valid_ff || s2_free;
      req_stall = !s1_free;
      s1_fire   = s1_valid_ff && s2_free;

      // input register
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_cap_in   = s1_cap_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
      end
      if (req_valid && s1_free) begin
         s1_op_in  = req_operation;
         s1_cap_in = req_capture_value;
      end

      // ring, slot, warm-up count and running sum
      sum_upd = sum_ff - papc_pkg::SUM_W'(ring_ff[slot_ff])
              + papc_pkg::SUM_W'(s1_cap_ff);
      ring_in = ring_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (s1_fire) begin
         if (s1_op_ff == papc_pkg::OP_OVERFLOW) begin
            for (int i = 0; i < papc_pkg::WINDOW; i++) begin
               ring_in[i] = '0;
            end
            slot_in = '0;
            fill_in = '0;
            sum_in  = '0;
         end else begin
            ring_in[slot_ff] = s1_cap_ff;
            slot_in = (slot_ff == papc_pkg::SLOT_W'(papc_pkg::WINDOW - 1)) ? '0
                    : slot_ff + papc_pkg::SLOT_W'(1);
            sum_in  = sum_upd;
            if (fill_ff != papc_pkg::FILL_W'(papc_pkg::WINDOW)) begin
               fill_in = fill_ff + papc_pkg::FILL_W'(1);
            end
         end
      end

      // sum stage; warm-up captures leave no item
      s2_valid_in = s2_valid_ff;
      s2_ovf_in   = s2_ovf_ff;
      s2_sum_in   = s2_sum_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff && ((s1_op_ff == papc_pkg::OP_OVERFLOW)
                       || (fill_ff == papc_pkg::FILL_W'(papc_pkg::WINDOW)));
         s2_ovf_in   = (s1_op_ff == papc_pkg::OP_OVERFLOW);
         s2_sum_in   = sum_upd;
      end

      // divide by window
      product   = papc_pkg::PROD_W'(s2_sum_ff) * papc_pkg::PROD_W'(papc_pkg::DIV_MULT);
      s3_valid_in = s3_valid_ff;
      s3_ovf_in   = s3_ovf_ff;
      s3_avg_in   = s3_avg_ff;
      if (s3_free) begin
         s3_valid_in = s2_valid_ff;
         s3_ovf_in   = s2_ovf_ff;
         s3_avg_in   = s2_ovf_ff ? '0 : product[papc_pkg::DIV_SHIFT +: papc_pkg::DATA_W];
      end

      // pitch bin
      for (int i = 0; i < papc_pkg::NUM_THRESH; i++) begin
         at_or_above[i] = (s3_avg_ff >= papc_pkg::THRESH[i]);
      end
      bin_leds[papc_pkg::LED_W-1] = !at_or_above[0];
      bin_leds[0] = at_or_above[papc_pkg::NUM_THRESH-1];
      for (int j = 1; j < papc_pkg::LED_W - 1; j++) begin
         bin_leds[j] = at_or_above[papc_pkg::NUM_THRESH-1-j]
                     && !at_or_above[papc_pkg::NUM_THRESH-j];
      end

      // result register
      rsp_valid_in = rsp_valid_ff;
      rsp_leds_in  = rsp_leds_ff;
      rsp_avg_in   = rsp_avg_ff;
      if (out_free) begin
         rsp_valid_in = s3_valid_ff;
         rsp_leds_in  = s3_ovf_ff ? '0 : bin_leds;
         rsp_avg_in   = s3_avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         for (int i = 0; i < papc_pkg::WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         ring_ff      <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_cap_ff   <= s1_cap_in;
      s2_ovf_ff   <= s2_ovf_in;
      s2_sum_ff   <= s2_sum_in;
      s3_ovf_ff   <= s3_ovf_in;
      s3_avg_ff   <= s3_avg_in;
      rsp_leds_ff <= rsp_leds_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_leds    = rsp_leds_ff;
   assign rsp_average = rsp_avg_ff;

   // overflow item empties the window
   `PAPC_ASSERT_NEXT(a_ovf_clears, clock, reset, s1_fire && s1_op_ff, (fill_ff == '0) && (sum_ff == '0))
   // warm-up count and slot stay in range
   `PAPC_ASSERT_NOW(a_state_range, clock, reset, 1'b1, (fill_ff <= papc_pkg::FILL_W'(papc_pkg::WINDOW)) && (slot_ff <= papc_pkg::SLOT_W'(papc_pkg::WINDOW - 1)))
   // an all-off pattern only comes with a zero average
   `PAPC_ASSERT_NOW(a_off_zero, clock, reset, rsp_valid && (rsp_leds == '0), rsp_average == '0)
   // a lit pattern has exactly one led
   `PAPC_ASSERT_NOW(a_one_hot, clock, reset, rsp_valid, $onehot0(rsp_leds))

endmodule

`default_nettype wire

/* verif/tb.sv */
// period_average_pitch_classifier testbench: random/directed captures and overflows
// depends on papc_pkg and the rtl top level; keeps its own window/average/bin model
`timescale 1ns / 1ps

module tb;

   localparam int AVG_LEN   = 5;
   localparam int BIN_COUNT = 14;
   localparam int RANDOM_ITEMS = 425;

   localparam logic [15:0] PITCH_STEPS [BIN_COUNT] = '{
      16'd8922, 16'd8948, 16'd8974, 16'd8999, 16'd9025, 16'd9052, 16'd9078,
      16'd9104, 16'd9130, 16'd9157, 16'd9184, 16'd9210, 16'd9236, 16'd9263
   };

   typedef struct packed {
      logic        op;
      logic [15:0] period;
   } edge_event_type;

   typedef struct packed {
      logic [14:0] leds;
      logic [15:0] average;
   } pitch_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = papc_pkg::OP_CAPTURE;
   logic [15:0] req_capture_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_leds;
   logic [15:0] rsp_average;

   edge_event_type    edge_events [$];
   pitch_reading_type pending_readings [$];

   logic [15:0] window_ring [AVG_LEN];
   int          window_slot;
   int          window_fill;
   logic [18:0] window_sum;

   bit          calm = 1'b0;
   int          send_gap = 0;
   int          hold_left = 0;
   int          errors = 0;
   int          captures_sent = 0;
   int          overflows_sent = 0;
   int          readings_checked = 0;
   logic [14:0] bins_lit = '0;

   period_average_pitch_classifier i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_capture_value (req_capture_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_leds          (rsp_leds),
      .rsp_average       (rsp_average)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < AVG_LEN; i++) window_ring[i] = '0;
      window_slot = 0;
      window_fill = 0;
      window_sum  = '0;
   endfunction

   // advance the averaging window by one accepted item, queue the reading it gives
   task automatic window_update(input logic op, input logic [15:0] period);
      pitch_reading_type r;
      int                n;
      logic [18:0]       avg;
      r = '0;
      n = 0;
      if (op == papc_pkg::OP_OVERFLOW) begin
         clear_window();
         pending_readings.push_back(r);
      end else begin
         window_sum = window_sum - 19'(window_ring[window_slot]) + 19'(period);
         window_ring[window_slot] = period;
         window_slot = (window_slot == AVG_LEN - 1) ? 0 : window_slot + 1;
         if (window_fill < AVG_LEN) begin
            window_fill++;
         end else begin
            avg = window_sum / AVG_LEN;
            for (int i = 0; i < BIN_COUNT; i++)
               if (avg >= 19'(PITCH_STEPS[i])) n++;
            r.leds    = 15'(1) << (BIN_COUNT - n);
            r.average = avg[15:0];
            pending_readings.push_back(r);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   task automatic queue_event(input logic op, input logic [15:0] period);
      edge_event_type e;
      e.op     = op;
      e.period = period;
      edge_events.push_back(e);
   endtask

   // driver
   always @(posedge clock) begin
      edge_event_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            window_update(req_operation, req_capture_value);
            if (req_operation == papc_pkg::OP_OVERFLOW) overflows_sent++;
            else captures_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (edge_events.size() > 0) begin
               e = edge_events.pop_front();
               req_valid         <= 1'b1;
               req_operation     <= e.op;
               req_capture_value <= e.period;
               send_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pitch_reading_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               report_mismatch("unexpected item, leds", int'(rsp_leds), 0);
            end else begin
               w = pending_readings.pop_front();
               if (rsp_leds !== w.leds)
                  report_mismatch("leds", int'(rsp_leds), int'(w.leds));
               if (rsp_average !== w.average)
                  report_mismatch("average", int'(rsp_average), int'(w.average));
               readings_checked++;
               bins_lit |= rsp_leds;
            end
            hold_left = draw_wait();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int          made;
      int          kind;
      int          len;
      logic [15:0] v;
      clear_window();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // overflow from reset, full-scale window, top threshold, zero window
      queue_event(papc_pkg::OP_OVERFLOW, 16'h0000);
      repeat (6) queue_event(papc_pkg::OP_CAPTURE, 16'hFFFF);
      queue_event(papc_pkg::OP_OVERFLOW, 16'h1234);
      repeat (6) queue_event(papc_pkg::OP_CAPTURE, 16'd9263);
      queue_event(papc_pkg::OP_OVERFLOW, 16'hFFFF);
      repeat (6) queue_event(papc_pkg::OP_CAPTURE, 16'h0000);
      queue_event(papc_pkg::OP_CAPTURE, 16'd44610);
      queue_event(papc_pkg::OP_CAPTURE, 16'd44598);
      queue_event(papc_pkg::OP_CAPTURE, 16'h5555);

      made = 0;
      while (made < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            // steady tone sitting on or next to one threshold
            v   = PITCH_STEPS[$urandom_range(0, BIN_COUNT - 1)];
            v   = v + 16'($urandom_range(0, 2)) - 16'd1;
            len = $urandom_range(6, 9);
            repeat (len) queue_event(papc_pkg::OP_CAPTURE, v);
         end else if (kind < 8) begin
            len = $urandom_range(4, 12);
            repeat (len)
               queue_event(papc_pkg::OP_CAPTURE, 16'($urandom_range(8850, 9350)));
         end else if (kind == 8) begin
            len = $urandom_range(1, 6);
            repeat (len)
               queue_event(papc_pkg::OP_CAPTURE, 16'($urandom_range(0, 65535)));
         end else begin
            len = 1;
            queue_event(papc_pkg::OP_OVERFLOW, 16'($urandom_range(0, 65535)));
         end
         made += len;
      end

      while (edge_events.size() != 0 || req_valid) @(posedge clock);
      calm = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d captures and %0d overflows, checked %0d result items",
               captures_sent, overflows_sent, readings_checked);
      $display("pitch bins lit at least once: %0d of 15", $countones(bins_lit));
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout waiting for result items");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
